// ===== hdl/crl_pkg.sv =====
// Shared types, constants and a helper function of the crystal link counter.
package crl_pkg;

    localparam int COMPONENT_BITS_DEFAULT = 16;
    localparam int MAX_LINKS_DEFAULT      = 63;

    localparam int ACC_BITS    = 36;
    localparam int THRESH_BITS = 16;
    localparam int COUNT_BITS  = 6;
    localparam int DATA_BITS   = 32;
    localparam int ADDR_BITS   = 3;

    localparam longint ACC_MAX = (longint'(1) <<< (ACC_BITS - 1)) - 1;
    localparam longint ACC_MIN = -ACC_MAX - 1;

    localparam logic [COUNT_BITS-1:0] LINK_COUNT_MAX = '1;

    localparam logic signed [THRESH_BITS-1:0] LINK_THRESHOLD_RESET = 16'sd16384;
    localparam logic [COUNT_BITS-1:0]         MIN_LINKS_RESET      = 6'd7;

    localparam logic REG_LINK_THRESHOLD = 1'b0;
    localparam logic REG_MIN_LINKS      = 1'b1;

    typedef struct packed {
        logic signed [THRESH_BITS-1:0] link_threshold;
        logic [COUNT_BITS-1:0]         min_links;
    } cfg_t;

    typedef struct packed {
        logic last_component;
        logic last_neighbour;
        logic no_neighbours;
    } flags_t;

    typedef struct packed {
        logic signed [ACC_BITS-1:0] re_prod;
        logic signed [ACC_BITS-1:0] im_prod;
        flags_t                     flags;
    } prod_t;

    // clamp a sum with one guard bit to the accumulator range
    function automatic logic signed [ACC_BITS-1:0] sat_acc(input logic signed [ACC_BITS:0] v);
        logic signed [ACC_BITS-1:0] r;
        if (v[ACC_BITS] != v[ACC_BITS-1])
        begin
            r = v[ACC_BITS] ? ACC_BITS'(ACC_MIN) : ACC_BITS'(ACC_MAX);
        end
        else
        begin
            r = v[ACC_BITS-1:0];
        end
        return r;
    endfunction

endpackage

// ===== hdl/crl_in_if.sv =====
// Input channel: one component pair word per handshake.
interface crl_in_if #(
    parameter int COMPONENT_BITS = crl_pkg::COMPONENT_BITS_DEFAULT
);
    logic                             valid;
    logic                             ready;
    logic signed [COMPONENT_BITS-1:0] local_re;
    logic signed [COMPONENT_BITS-1:0] local_im;
    logic signed [COMPONENT_BITS-1:0] neigh_re;
    logic signed [COMPONENT_BITS-1:0] neigh_im;
    logic                             last_component;
    logic                             last_neighbour;
    logic                             no_neighbours;

    modport source (
        output valid, local_re, local_im, neigh_re, neigh_im,
               last_component, last_neighbour, no_neighbours,
        input  ready
    );

    modport sink (
        input  valid, local_re, local_im, neigh_re, neigh_im,
               last_component, last_neighbour, no_neighbours,
        output ready
    );
endinterface

// ===== hdl/crl_out_if.sv =====
// Output channel: one link count word per particle.
interface crl_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [crl_pkg::COUNT_BITS-1:0]       link_count;
    logic                                 crystalline;

    modport source (
        output valid, link_count, crystalline,
        input  ready
    );

    modport sink (
        input  valid, link_count, crystalline,
        output ready
    );
endinterface

// ===== hdl/crl_regs.sv =====
// APB configuration registers: link threshold and minimum links.
module crl_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [crl_pkg::ADDR_BITS-1:0] paddr,
    input  logic [crl_pkg::DATA_BITS-1:0] pwdata,
    output logic [crl_pkg::DATA_BITS-1:0] prdata,
    output logic                          pready,
    output crl_pkg::cfg_t                 cfg
);
    import crl_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;
    logic reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[ADDR_BITS-1];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_sel)
                REG_LINK_THRESHOLD: cfg_next.link_threshold = pwdata[THRESH_BITS-1:0];
                REG_MIN_LINKS:      cfg_next.min_links      = pwdata[COUNT_BITS-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.link_threshold <= LINK_THRESHOLD_RESET;
            cfg_reg.min_links      <= MIN_LINKS_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_LINK_THRESHOLD: prdata = DATA_BITS'(cfg_reg.link_threshold);
            REG_MIN_LINKS:      prdata = DATA_BITS'(cfg_reg.min_links);
            default:            prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ===== hdl/crl_dot.sv =====
// Input register and product stage: two signed multiplies, clamped to the accumulator range.
module crl_dot #(
    parameter int COMPONENT_BITS = crl_pkg::COMPONENT_BITS_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    crl_in_if.sink         item_in,
    output logic           prod_valid,
    output crl_pkg::prod_t prod,
    input  logic           prod_ready
);
    import crl_pkg::*;

    localparam int PW = 2 * COMPONENT_BITS;
    localparam int WW = (PW > ACC_BITS) ? PW : ACC_BITS;
    localparam logic signed [WW-1:0] SAT_HI = WW'(ACC_MAX);
    localparam logic signed [WW-1:0] SAT_LO = WW'(ACC_MIN);

    logic                             in_valid_reg;
    logic signed [COMPONENT_BITS-1:0] lre_reg;
    logic signed [COMPONENT_BITS-1:0] lim_reg;
    logic signed [COMPONENT_BITS-1:0] nre_reg;
    logic signed [COMPONENT_BITS-1:0] nim_reg;
    flags_t                           flags_reg;

    logic                             prod_valid_reg;
    prod_t                            prod_reg;
    prod_t                            prod_next;

    logic signed [PW-1:0]             re_full;
    logic signed [PW-1:0]             im_full;
    logic signed [WW-1:0]             re_ext;
    logic signed [WW-1:0]             im_ext;

    assign item_in.ready = !in_valid_reg || prod_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item_in.ready)
        begin
            in_valid_reg <= item_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_in.valid && item_in.ready)
        begin
            lre_reg                  <= item_in.local_re;
            lim_reg                  <= item_in.local_im;
            nre_reg                  <= item_in.neigh_re;
            nim_reg                  <= item_in.neigh_im;
            flags_reg.last_component <= item_in.last_component;
            flags_reg.last_neighbour <= item_in.last_neighbour;
            flags_reg.no_neighbours  <= item_in.no_neighbours;
        end
    end

    always_comb
    begin
        re_full = PW'(lre_reg) * PW'(nre_reg);
        im_full = PW'(lim_reg) * PW'(nim_reg);
        re_ext  = WW'(re_full);
        im_ext  = WW'(im_full);

        prod_next.flags = flags_reg;
        if (re_ext > SAT_HI)
        begin
            prod_next.re_prod = ACC_BITS'(SAT_HI);
        end
        else if (re_ext < SAT_LO)
        begin
            prod_next.re_prod = ACC_BITS'(SAT_LO);
        end
        else
        begin
            prod_next.re_prod = ACC_BITS'(re_ext);
        end
        if (im_ext > SAT_HI)
        begin
            prod_next.im_prod = ACC_BITS'(SAT_HI);
        end
        else if (im_ext < SAT_LO)
        begin
            prod_next.im_prod = ACC_BITS'(SAT_LO);
        end
        else
        begin
            prod_next.im_prod = ACC_BITS'(im_ext);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
        end
        else if (prod_ready)
        begin
            prod_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (prod_ready && in_valid_reg)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod_valid = prod_valid_reg;
    assign prod       = prod_reg;

endmodule

// ===== hdl/crl_count.sv =====
// Accumulate stage: dot product sum, threshold compare, link count and result register.
module crl_count #(
    parameter int COMPONENT_BITS = crl_pkg::COMPONENT_BITS_DEFAULT,
    parameter int MAX_LINKS      = crl_pkg::MAX_LINKS_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  crl_pkg::cfg_t  cfg,
    input  logic           prod_valid,
    input  crl_pkg::prod_t prod,
    output logic           prod_ready,
    crl_out_if.source      result_out
);
    import crl_pkg::*;

    localparam int LW    = $clog2(MAX_LINKS + 1);
    localparam int EW    = (LW > COUNT_BITS) ? LW : COUNT_BITS;
    localparam int SHIFT = 2 * COMPONENT_BITS - 17;
    localparam int SH_T  = (SHIFT >= 0) ? SHIFT : 0;
    localparam int SH_A  = (SHIFT < 0) ? -SHIFT : 0;
    localparam int CW_A  = ACC_BITS + SH_A;
    localparam int CW_T  = THRESH_BITS + SH_T;
    localparam int CW    = ((CW_A > CW_T) ? CW_A : CW_T) + 1;

    logic signed [ACC_BITS-1:0] acc_reg;
    logic signed [ACC_BITS-1:0] acc_next;
    logic [LW-1:0]              links_reg;
    logic [LW-1:0]              links_next;

    logic                       out_valid_reg;
    logic [COUNT_BITS-1:0]      link_count_reg;
    logic                       crystalline_reg;
    logic [COUNT_BITS-1:0]      link_count_next;
    logic                       crystalline_next;

    logic signed [ACC_BITS-1:0] pair;
    logic signed [ACC_BITS-1:0] acc_sum;
    logic signed [CW-1:0]       lhs;
    logic signed [CW-1:0]       rhs;
    logic                       reached;
    logic [LW-1:0]              links_upd;
    logic [EW-1:0]              cnt_ext;
    logic                       emits;
    logic                       fire;

    assign emits = prod.flags.no_neighbours
                || (prod.flags.last_component && prod.flags.last_neighbour);
    assign fire       = prod_valid && (!emits || !out_valid_reg || result_out.ready);
    assign prod_ready = !prod_valid || fire;

    always_comb
    begin
        pair    = sat_acc((ACC_BITS + 1)'(prod.re_prod) + (ACC_BITS + 1)'(prod.im_prod));
        acc_sum = sat_acc((ACC_BITS + 1)'(acc_reg) + (ACC_BITS + 1)'(pair));
        lhs     = CW'(acc_sum) <<< SH_A;
        rhs     = CW'(cfg.link_threshold) <<< SH_T;
        reached = lhs >= rhs;

        links_upd = links_reg;
        if (reached && (links_reg < LW'(MAX_LINKS)))
        begin
            links_upd = links_reg + LW'(1);
        end

        acc_next   = acc_reg;
        links_next = links_reg;
        cnt_ext    = '0;
        if (prod.flags.no_neighbours)
        begin
            acc_next   = '0;
            links_next = '0;
        end
        else if (prod.flags.last_component)
        begin
            acc_next   = '0;
            links_next = prod.flags.last_neighbour ? '0 : links_upd;
            cnt_ext    = EW'(links_upd);
        end
        else
        begin
            acc_next = acc_sum;
        end

        link_count_next  = (cnt_ext > EW'(LINK_COUNT_MAX)) ? LINK_COUNT_MAX
                                                           : cnt_ext[COUNT_BITS-1:0];
        crystalline_next = cnt_ext >= EW'(cfg.min_links);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            links_reg <= '0;
        end
        else if (fire)
        begin
            acc_reg   <= acc_next;
            links_reg <= links_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire && emits)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && emits)
        begin
            link_count_reg  <= link_count_next;
            crystalline_reg <= crystalline_next;
        end
    end

    assign result_out.valid       = out_valid_reg;
    assign result_out.link_count  = link_count_reg;
    assign result_out.crystalline = crystalline_reg;

endmodule

// ===== hdl/crystal_link_counter.sv =====
// Top level of the crystal link counter.
// Takes one component pair word per clock and returns one word (link count and crystalline
// flag) per particle. The word ending the particle passes an input register, a product
// register holding the two clamped multiplies and the accumulate stage, whose accumulator
// register feeds back on itself and which writes the result register. item_in.ready drops
// only while a result word waits unread and the word in the accumulate stage would produce
// the next result. Configuration must be written over APB only while the block is idle;
// the block itself does not enforce this. Registers sit at byte addresses 0
// (link_threshold) and 4 (min_links).
module crystal_link_counter #(
    parameter int COMPONENT_BITS = crl_pkg::COMPONENT_BITS_DEFAULT,
    parameter int MAX_LINKS      = crl_pkg::MAX_LINKS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [crl_pkg::ADDR_BITS-1:0] paddr,
    input  logic [crl_pkg::DATA_BITS-1:0] pwdata,
    output logic [crl_pkg::DATA_BITS-1:0] prdata,
    output logic                          pready,
    crl_in_if.sink                        item_in,
    crl_out_if.source                     result_out
);
    import crl_pkg::*;

    cfg_t  cfg;
    logic  prod_valid;
    prod_t prod;
    logic  prod_ready;

    crl_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    crl_dot #(
        .COMPONENT_BITS (COMPONENT_BITS)
    ) u_dot (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_in),
        .prod_valid (prod_valid),
        .prod       (prod),
        .prod_ready (prod_ready)
    );

    crl_count #(
        .COMPONENT_BITS (COMPONENT_BITS),
        .MAX_LINKS      (MAX_LINKS)
    ) u_count (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .prod_valid (prod_valid),
        .prod       (prod),
        .prod_ready (prod_ready),
        .result_out (result_out)
    );

endmodule

// ===== tb/crl_link_checker.sv =====
// Checker for the crystal link counter: follows APB writes and input words, predicts link counts.
module crl_link_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic                          pready,
    input  logic [crl_pkg::ADDR_BITS-1:0] paddr,
    input  logic [crl_pkg::DATA_BITS-1:0] pwdata,
    crl_in_if                             item_ch,
    crl_out_if                            res_ch,
    output int                            fail_count,
    output int                            pending,
    output int                            particles_seen
);
    import crl_pkg::*;

    localparam int PROD_SHIFT = 2 * COMPONENT_BITS_DEFAULT - 17;

    typedef struct packed {
        logic [COUNT_BITS-1:0] link_count;
        logic                  crystalline;
    } tally_t;

    tally_t                        tallies_due[$];
    logic signed [THRESH_BITS-1:0] threshold_q;
    logic [COUNT_BITS-1:0]         min_links_q;
    longint                        dot_sum;
    int                            links_held;
    int                            mismatches;
    int                            tallies_checked;

    assign fail_count     = mismatches;
    assign particles_seen = tallies_checked;

    function automatic longint clamp_acc(longint v);
        if (v > ACC_MAX)
        begin
            return ACC_MAX;
        end
        if (v < ACC_MIN)
        begin
            return ACC_MIN;
        end
        return v;
    endfunction

    function automatic tally_t tally_of(int links);
        tally_t t;
        t.link_count  = (links > int'(LINK_COUNT_MAX)) ? LINK_COUNT_MAX : COUNT_BITS'(links);
        t.crystalline = (links >= int'(min_links_q));
        return t;
    endfunction

    task automatic report(string what, int got, int want);
        $display("checker: %s mismatch at %0t: got %0d, want %0d", what, $time, got, want);
        mismatches++;
    endtask

    task automatic absorb_word();
        longint pair;
        if (item_ch.no_neighbours)
        begin
            dot_sum    = 0;
            links_held = 0;
            tallies_due.insert(tallies_due.size(), tally_of(0));
        end
        else
        begin
            pair = clamp_acc(clamp_acc(longint'(item_ch.local_re) * longint'(item_ch.neigh_re))
                           + clamp_acc(longint'(item_ch.local_im) * longint'(item_ch.neigh_im)));
            dot_sum = clamp_acc(dot_sum + pair);
            if (item_ch.last_component)
            begin
                if (dot_sum >= (longint'(threshold_q) <<< PROD_SHIFT)
                    && links_held < MAX_LINKS_DEFAULT)
                begin
                    links_held++;
                end
                dot_sum = 0;
                if (item_ch.last_neighbour)
                begin
                    tallies_due.insert(tallies_due.size(), tally_of(links_held));
                    links_held = 0;
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        tally_t want;
        if (!rst_n)
        begin
            tallies_due.delete();
            threshold_q     = LINK_THRESHOLD_RESET;
            min_links_q     = MIN_LINKS_RESET;
            dot_sum         = 0;
            links_held      = 0;
            mismatches      = 0;
            tallies_checked = 0;
            pending        <= 0;
        end
        else
        begin
            // output first: a result cannot come from the word accepted at this edge
            if (res_ch.valid && res_ch.ready)
            begin
                if (tallies_due.size() == 0)
                begin
                    report("unexpected result word", res_ch.link_count, -1);
                end
                else
                begin
                    want = tallies_due.pop_front();
                    tallies_checked++;
                    if (res_ch.link_count !== want.link_count)
                    begin
                        report("link_count", res_ch.link_count, want.link_count);
                    end
                    if (res_ch.crystalline !== want.crystalline)
                    begin
                        report("crystalline", res_ch.crystalline, want.crystalline);
                    end
                end
            end
            if (item_ch.valid && item_ch.ready)
            begin
                absorb_word();
            end
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_LINK_THRESHOLD)
                begin
                    threshold_q = pwdata[THRESH_BITS-1:0];
                end
                else
                begin
                    min_links_q = pwdata[COUNT_BITS-1:0];
                end
            end
            pending <= tallies_due.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
// Top of the crystal link counter bench: clock, reset, APB setup, word stimulus and verdict.
module testbench;
    import crl_pkg::*;

    localparam int CB          = COMPONENT_BITS_DEFAULT;
    localparam int IDLE_LIMIT  = 3000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 8;
    localparam int RANDOM_GOAL = 780;
    localparam int PHASE_GOAL  = 195;

    typedef enum int {STYLE_RANDOM, STYLE_ALIGNED, STYLE_OPPOSED, STYLE_EXTREME} comp_style_t;

    typedef struct {
        logic signed [CB-1:0] lre;
        logic signed [CB-1:0] lim;
        logic signed [CB-1:0] nre;
        logic signed [CB-1:0] nim;
        logic                 last_comp;
        logic                 last_neigh;
        logic                 no_neigh;
    } pair_word_t;

    logic                 clk;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_BITS-1:0] paddr;
    logic [DATA_BITS-1:0] pwdata;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;

    int fail_count;
    int pending;
    int particles_seen;
    int words_sent;
    int settings_used;
    int idle_run;
    bit quiet;
    bit hold_req;

    crl_in_if #(.COMPONENT_BITS(CB)) in_ch ();
    crl_out_if                       out_ch ();

    crystal_link_counter dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .item_in    (in_ch),
        .result_out (out_ch)
    );

    crl_link_checker link_chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .item_ch        (in_ch),
        .res_ch         (out_ch),
        .fail_count     (fail_count),
        .pending        (pending),
        .particles_seen (particles_seen)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (psel && penable))
        begin
            idle_run <= 0;
        end
        else if (idle_run >= IDLE_LIMIT)
        begin
            $display("testbench: done, errors");
            $finish;
        end
        else
        begin
            idle_run <= idle_run + 1;
        end
    end

    // result side: random stall bursts, one long hold-off on request
    initial
    begin
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_req = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(0, 6)) @(negedge clk);
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    function automatic int rand16();
        return $urandom_range(0, 65535) - 32768;
    endfunction

    function automatic int pick_extreme();
        return $urandom_range(0, 1) ? 32767 : -32768;
    endfunction

    function automatic pair_word_t make_word(int lre, int lim, int nre, int nim,
                                             bit lc, bit ln, bit nn);
        pair_word_t w;
        w.lre        = CB'(lre);
        w.lim        = CB'(lim);
        w.nre        = CB'(nre);
        w.nim        = CB'(nim);
        w.last_comp  = lc;
        w.last_neigh = ln;
        w.no_neigh   = nn;
        return w;
    endfunction

    task automatic push_word(pair_word_t w);
        @(negedge clk);
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.local_re       <= w.lre;
        in_ch.local_im       <= w.lim;
        in_ch.neigh_re       <= w.nre;
        in_ch.neigh_im       <= w.nim;
        in_ch.last_component <= w.last_comp;
        in_ch.last_neighbour <= w.last_neigh;
        in_ch.no_neighbours  <= w.no_neigh;
        do @(posedge clk); while (!in_ch.ready);
        words_sent++;
    endtask

    task automatic apb_write(logic [ADDR_BITS-1:0] addr, logic [DATA_BITS-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // stop offering words, wait out expected results and the pipeline tail
    task automatic drain();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    task automatic apply_settings(int thr, int minl);
        drain();
        apb_write({REG_LINK_THRESHOLD, 2'b00}, DATA_BITS'(thr));
        apb_write({REG_MIN_LINKS, 2'b00}, DATA_BITS'(minl));
        settings_used++;
    endtask

    // one-component neighbours, all the same data
    task automatic send_run(int nneigh, int lre, int lim, int nre, int nim);
        for (int n = 0; n < nneigh; n++)
        begin
            push_word(make_word(lre, lim, nre, nim, 1'b1, n == nneigh - 1, 1'b0));
        end
    endtask

    task automatic send_neighbour(int ncomp, comp_style_t style, bit last_neigh);
        int lre;
        int lim;
        int nre;
        int nim;
        bit is_last;
        for (int c = 0; c < ncomp; c++)
        begin
            lre = rand16();
            lim = rand16();
            nre = rand16();
            nim = rand16();
            case (style)
                STYLE_ALIGNED:
                begin
                    lre = lre >>> $urandom_range(0, 2);
                    lim = lim >>> $urandom_range(0, 2);
                    nre = lre;
                    nim = lim;
                end
                STYLE_OPPOSED:
                begin
                    nre = -lre;
                    nim = -lim;
                end
                STYLE_EXTREME:
                begin
                    lre = pick_extreme();
                    lim = pick_extreme();
                    nre = pick_extreme();
                    nim = pick_extreme();
                end
                default:
                begin
                end
            endcase
            is_last = (c == ncomp - 1);
            push_word(make_word(lre, lim, nre, nim, is_last,
                                is_last ? last_neigh : ($urandom_range(0, 9) == 0), 1'b0));
        end
    endtask

    task automatic send_particle();
        int sel;
        int nneigh;
        sel = $urandom_range(0, 19);
        if (sel == 0)
        begin
            push_word(make_word(rand16(), rand16(), rand16(), rand16(),
                                $urandom_range(0, 1), $urandom_range(0, 1), 1'b1));
        end
        else
        begin
            nneigh = $urandom_range(1, 10);
            for (int n = 0; n < nneigh; n++)
            begin
                // sel 1: particle cut short, its links run into the next one
                send_neighbour(($urandom_range(0, 7) == 0) ? 13 : $urandom_range(1, 6),
                               comp_style_t'($urandom_range(0, 3)),
                               (n == nneigh - 1) && (sel != 1));
            end
        end
    endtask

    initial
    begin
        int mark;
        int random_start;
        rst_n                = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        in_ch.valid          = 1'b0;
        in_ch.local_re       = '0;
        in_ch.local_im       = '0;
        in_ch.neigh_re       = '0;
        in_ch.neigh_im       = '0;
        in_ch.last_component = 1'b0;
        in_ch.last_neighbour = 1'b0;
        in_ch.no_neighbours  = 1'b0;
        quiet                = 1'b0;
        hold_req             = 1'b0;
        words_sent           = 0;
        settings_used        = 1;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: threshold 0.5, seven links
        push_word(make_word(32767, -32768, 32767, -32768, 1'b1, 1'b1, 1'b1));
        push_word(make_word(32767, 32767, 32767, 32767, 1'b1, 1'b0, 1'b0));
        push_word(make_word(-32768, -32768, -32768, -32768, 1'b0, 1'b1, 1'b0));
        push_word(make_word(0, 0, 0, 0, 1'b1, 1'b0, 1'b0));
        push_word(make_word(-32768, 32767, 32767, -32768, 1'b1, 1'b1, 1'b0));
        // exactly on the threshold, then one step below
        push_word(make_word(16384, 16384, 16384, 16384, 1'b1, 1'b0, 1'b0));
        push_word(make_word(16384, 16384, 16383, 16384, 1'b1, 1'b1, 1'b0));
        // no-neighbour word in mid particle clears the tally
        push_word(make_word(32767, 0, 32767, 0, 1'b1, 1'b0, 1'b0));
        push_word(make_word(0, 0, 0, 0, 1'b0, 1'b0, 1'b1));
        push_word(make_word(0, 0, 0, 0, 1'b1, 1'b1, 1'b0));
        send_run(7, 32767, 32767, 32767, 32767);

        apply_settings(-32768, 0);
        push_word(make_word(rand16(), rand16(), rand16(), rand16(), 1'b0, 1'b0, 1'b1));
        send_run(70, 0, 0, 0, 0);
        // accumulator pinned at both ends
        for (int i = 0; i < 40; i++)
        begin
            push_word(make_word(32767, 32767, -32768, -32768, i == 39, 1'b0, 1'b0));
        end
        for (int i = 0; i < 40; i++)
        begin
            push_word(make_word(-32768, -32768, -32768, -32768, i == 39, 1'b1, 1'b0));
        end

        apply_settings(32767, 63);
        send_run(64, 32767, 32767, 32767, 32767);
        send_run(2, 32767, 32767, 32767, 32767);
        push_word(make_word(0, 0, 0, 0, 1'b1, 1'b1, 1'b1));

        apply_settings(0, 1);
        send_run(1, 0, 0, 0, 0);

        random_start = words_sent;
        for (int phase = 0; phase < 4; phase++)
        begin
            if (phase == 3)
            begin
                quiet = 1'b1;
            end
            apply_settings(($urandom_range(0, 3) == 0) ? rand16() : $urandom_range(0, 24576) - 8192,
                           ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                       : $urandom_range(0, 10));
            mark = words_sent;
            if (phase == 1)
            begin
                send_particle();
                hold_req = 1'b1;
            end
            while ((phase < 3) ? (words_sent - mark < PHASE_GOAL)
                               : (words_sent - random_start < RANDOM_GOAL))
            begin
                send_particle();
            end
        end

        drain();
        $display("testbench: %0d words sent, %0d particle results checked",
                 words_sent, particles_seen);
        $display("testbench: %0d register settings, threshold and min_links at both ends",
                 settings_used);
        if (fail_count == 0 && pending == 0)
        begin
            $display("testbench: done, clean");
        end
        else
        begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
